### rtl/cht_pkg.sv
// Shared constants and codes for the chained hash table with usage aging.
`default_nettype none

package cht_pkg;

    localparam int BUCKETS_DEF  = 128;
    localparam int CAPACITY_DEF = 256;

    localparam int FUNC_W  = 3;
    localparam int KEY_W   = 31;
    localparam int DATA_W  = 31;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;
    localparam int USAGE_W = 16;

    localparam logic signed [USAGE_W-1:0] USAGE_MAX = 16'sh7fff;
    localparam logic signed [USAGE_W-1:0] USAGE_MIN = 16'sh8000;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 3'd0,
        FN_GET    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_AGE    = 3'd3,
        FN_SWEEP  = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/chained_hash_table_with_aging_top.sv
// Top level of the chained hash table with usage aging.
//
//  Channel   Signals                                       Direction
//  --------  --------------------------------------------  ---------
//  command   start, busy, i_func, i_key, i_data_in         in
//  result    o_valid, o_status, o_data_out, o_entry_count  out
//
// A command transfer happens at a rising edge with start high and busy low.
// Put, get and remove first reduce the key to a bucket by multiplying with a
// constant reciprocal (HASH, MOD) and then read the chain head (HEAD).
// Put then scans the pool for the lowest free slot, one slot per cycle; get and
// remove walk the chain, one entry per cycle, and remove then frees the slot.
// Age visits every pool slot; sweep walks the chain of every bucket.
// A put into a full table and an undefined code answer in the next cycle.
// After reset a clearing pass over the head table and the pool keeps busy high.
// Each result is shown for one cycle with o_valid; the receiver cannot stall it.
`default_nettype none

module chained_hash_table_with_aging_top
    import cht_pkg::*;
#(
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [KEY_W-1:0]    i_key,
    input  wire logic [DATA_W-1:0]   i_data_in,
    output logic                     o_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic [DATA_W-1:0]        o_data_out,
    output logic [COUNT_W-1:0]       o_entry_count
);

    // Slot pointers carry one extra code, CAPACITY, that marks an empty chain.
    localparam int SW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MAXN = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
    localparam int CW   = $clog2(MAXN + 1);

    // The quotient key / BUCKETS is (key * RECIP) >> SH, exact for every key.
    localparam int LB  = $clog2(BUCKETS);
    localparam int SH  = KEY_W + LB;
    localparam int MW  = KEY_W + 1;
    localparam int PRW = KEY_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam logic [BW-1:0] B_LOW = BW'(BUCKETS);

    localparam logic [SW-1:0] NIL = SW'(CAPACITY);

    // One pool word holds everything about a slot, so a single memory serves.
    typedef struct packed {
        logic                       used;
        logic signed [USAGE_W-1:0]  usage;
        logic [SW-1:0]              nxt;
        logic [KEY_W-1:0]           key;
        logic [DATA_W-1:0]          value;
    } t_slot;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_HEAD,
        S_PUT,
        S_WALK_HD,
        S_WALK,
        S_FREE,
        S_AGE,
        S_SW_RD,
        S_SW_HD,
        S_SW
    } t_state;

    // Memories with registered read data.
    logic [SW-1:0] head_mem [BUCKETS];
    t_slot         pool_mem [CAPACITY];

    logic          head_re, head_we;
    logic [BW-1:0] head_raddr, head_waddr;
    logic [SW-1:0] head_wdata;
    logic [SW-1:0] r_head_rd;

    logic          pool_re, pool_we;
    logic [PW-1:0] pool_raddr, pool_waddr;
    t_slot         pool_wdata;
    t_slot         r_pool_rd;

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            r_head_rd <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        if (pool_re) begin
            r_pool_rd <= pool_mem[pool_raddr];
        end
    end

    // Control and working registers.
    t_state             r_state, n_state;
    t_func              r_func, n_func;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [PRW-1:0]     r_prod, n_prod;
    logic [BW-1:0]      r_rem, n_rem;
    logic [CW-1:0]      r_idx, n_idx;
    logic [SW-1:0]      r_cur, n_cur;
    logic [SW-1:0]      r_prev, n_prev;
    logic [SW-1:0]      r_nxt, n_nxt;
    t_slot              r_prev_word, n_prev_word;
    logic [BW-1:0]      r_b, n_b;
    logic [SW-1:0]      r_count, n_count;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_data_out, n_data_out;

    logic [CW-1:0]      idx_inc;
    logic [BW-1:0]      bucket;
    t_slot              w;
    t_slot              upd;
    logic               last_b;

    assign bucket  = r_rem;
    assign idx_inc = r_idx + CW'(1);
    assign w       = r_pool_rd;
    assign last_b  = (r_b == BW'(BUCKETS - 1));

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_data      = r_data;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_prev_word = r_prev_word;
        n_b         = r_b;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_data_out  = r_data_out;

        head_re    = 1'b0;
        head_raddr = bucket;
        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = NIL;
        pool_re    = 1'b0;
        pool_raddr = r_cur[PW-1:0];
        pool_we    = 1'b0;
        pool_waddr = r_cur[PW-1:0];
        pool_wdata = '0;

        upd       = w;

        unique case (r_state)
            S_CLEAR: begin
                head_we    = (r_idx < CW'(BUCKETS));
                head_waddr = r_idx[BW-1:0];
                pool_we    = (r_idx < CW'(CAPACITY));
                pool_waddr = r_idx[PW-1:0];
                if (r_idx == CW'(MAXN - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_func     = t_func'(i_func);
                    n_key      = i_key;
                    n_data     = i_data_in;
                    n_rem      = '0;
                    n_idx      = '0;
                    n_b        = '0;
                    n_data_out = '0;
                    unique case (i_func)
                        FN_PUT: begin
                            if (r_count == NIL) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_state = S_HASH;
                            end
                        end
                        FN_GET, FN_REMOVE: begin
                            n_state = S_HASH;
                        end
                        FN_AGE: begin
                            pool_re    = 1'b1;
                            pool_raddr = '0;
                            n_state    = S_AGE;
                        end
                        FN_SWEEP: begin
                            n_state = S_SW_RD;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            // Quotient by reciprocal multiplication, registered in r_prod.
            S_HASH: begin
                n_prod  = PRW'(r_key) * PRW'(RECIP);
                n_state = S_MOD;
            end

            // The remainder is below 2**BW, so the low bits of key - q * BUCKETS suffice.
            S_MOD: begin
                n_rem   = r_key[BW-1:0] - r_prod[SH +: BW] * B_LOW;
                n_state = S_HEAD;
            end

            S_HEAD: begin
                head_re = 1'b1;
                if (r_func == FN_PUT) begin
                    pool_re    = 1'b1;
                    pool_raddr = '0;
                    n_idx      = '0;
                    n_state    = S_PUT;
                end else begin
                    n_state = S_WALK_HD;
                end
            end

            S_PUT: begin
                if (!w.used) begin
                    pool_we          = 1'b1;
                    pool_waddr       = r_idx[PW-1:0];
                    pool_wdata.used  = 1'b1;
                    pool_wdata.usage = '0;
                    pool_wdata.nxt   = r_head_rd;
                    pool_wdata.key   = r_key;
                    pool_wdata.value = r_data;
                    head_we          = 1'b1;
                    head_wdata       = r_idx[SW-1:0];
                    n_count          = r_count + SW'(1);
                    n_valid          = 1'b1;
                    n_status         = ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    pool_re    = 1'b1;
                    pool_raddr = idx_inc[PW-1:0];
                    n_idx      = idx_inc;
                end
            end

            S_WALK_HD: begin
                n_cur  = r_head_rd;
                n_prev = NIL;
                if (r_head_rd == NIL) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else begin
                    pool_re    = 1'b1;
                    pool_raddr = r_head_rd[PW-1:0];
                    n_state    = S_WALK;
                end
            end

            S_WALK: begin
                if (w.key == r_key) begin
                    if (r_func == FN_GET) begin
                        if (w.usage != USAGE_MAX) begin
                            upd.usage = w.usage + 16'sd1;
                        end
                        pool_we    = 1'b1;
                        pool_wdata = upd;
                        n_data_out = w.value;
                        n_valid    = 1'b1;
                        n_status   = ST_OK;
                        n_state    = S_IDLE;
                    end else begin
                        if (r_prev == NIL) begin
                            head_we    = 1'b1;
                            head_wdata = w.nxt;
                        end else begin
                            pool_we        = 1'b1;
                            pool_waddr     = r_prev[PW-1:0];
                            pool_wdata     = r_prev_word;
                            pool_wdata.nxt = w.nxt;
                        end
                        n_count = r_count - SW'(1);
                        n_state = S_FREE;
                    end
                end else begin
                    n_prev      = r_cur;
                    n_prev_word = w;
                    n_cur       = w.nxt;
                    if (w.nxt == NIL) begin
                        n_valid  = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_state  = S_IDLE;
                    end else begin
                        pool_re    = 1'b1;
                        pool_raddr = w.nxt[PW-1:0];
                    end
                end
            end

            // Second half of an unlink: the slot itself goes back to the pool.
            S_FREE: begin
                pool_we = 1'b1;
                if (r_func == FN_REMOVE) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_cur = r_nxt;
                    if (r_nxt != NIL) begin
                        pool_re    = 1'b1;
                        pool_raddr = r_nxt[PW-1:0];
                        n_state    = S_SW;
                    end else if (last_b) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        n_b     = r_b + BW'(1);
                        n_state = S_SW_RD;
                    end
                end
            end

            S_AGE: begin
                if (w.used && (w.usage != USAGE_MIN)) begin
                    upd.usage  = w.usage - 16'sd1;
                    pool_we    = 1'b1;
                    pool_waddr = r_idx[PW-1:0];
                    pool_wdata = upd;
                end
                if (r_idx == CW'(CAPACITY - 1)) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    pool_re    = 1'b1;
                    pool_raddr = idx_inc[PW-1:0];
                    n_idx      = idx_inc;
                end
            end

            S_SW_RD: begin
                head_re    = 1'b1;
                head_raddr = r_b;
                n_state    = S_SW_HD;
            end

            S_SW_HD: begin
                n_cur  = r_head_rd;
                n_prev = NIL;
                if (r_head_rd != NIL) begin
                    pool_re    = 1'b1;
                    pool_raddr = r_head_rd[PW-1:0];
                    n_state    = S_SW;
                end else if (last_b) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_b     = r_b + BW'(1);
                    n_state = S_SW_RD;
                end
            end

            S_SW: begin
                n_nxt = w.nxt;
                if (w.usage <= 16'sd0) begin
                    if (r_prev == NIL) begin
                        head_we    = 1'b1;
                        head_waddr = r_b;
                        head_wdata = w.nxt;
                    end else begin
                        pool_we         = 1'b1;
                        pool_waddr      = r_prev[PW-1:0];
                        pool_wdata      = r_prev_word;
                        pool_wdata.nxt  = w.nxt;
                        n_prev_word.nxt = w.nxt;
                    end
                    n_count = r_count - SW'(1);
                    n_state = S_FREE;
                end else begin
                    upd.usage   = '0;
                    pool_we     = 1'b1;
                    pool_wdata  = upd;
                    n_prev      = r_cur;
                    n_prev_word = upd;
                    n_cur       = w.nxt;
                    if (w.nxt != NIL) begin
                        pool_re    = 1'b1;
                        pool_raddr = w.nxt[PW-1:0];
                    end else if (last_b) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        n_b     = r_b + BW'(1);
                        n_state = S_SW_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_func      <= n_func;
        r_key       <= n_key;
        r_data      <= n_data;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_nxt       <= n_nxt;
        r_prev_word <= n_prev_word;
        r_b         <= n_b;
        r_status    <= n_status;
        r_data_out  <= n_data_out;
    end

    // The count only changes while busy, so it is stable during the strobe.
    logic [SW+COUNT_W-1:0] cnt_ext;
    assign cnt_ext = {{COUNT_W{1'b0}}, r_count};

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_data_out    = r_data_out;
    assign o_entry_count = cnt_ext[COUNT_W-1:0];

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("stored count exceeds capacity");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_data_out == '0))
        else $error("data returned with a failing status");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_full_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (r_count == NIL))
        else $error("full status while slots remain");
`endif

endmodule

`default_nettype wire
